// File: rtl/core/mtfq_pkg.sv
// Move-to-front queue: shared types and codes.
// Used by mtfq_cell, move_to_front_queue and mtfq_checker; depends on nothing.
package mtfq_pkg;

  localparam int CMD_W    = 2;
  localparam int PRI_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_AT_HEAD   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd5;

  // search token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic head;
  } probe_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic wr_en;
    logic shift_en;
    logic is_read;
  } cell_ctrl_t;

endpackage

// File: rtl/core/move_to_front_queue.sv
// Move-to-front queue top level: control, result register and the row of cells.
// Depends on mtfq_pkg and mtfq_cell.
//
// Holds up to CAPACITY (key, priority) entries in a row of cells, head at cell 0.
// One word is taken at a time. Append, promote on an empty table and the
// unused command go from acceptance straight to the done state, which loads
// the output register once it is free. Promote and read send a search token
// down the row, one cell per clock, through the start and walk states; a
// promote that moves an entry then passes through the shift state before done.
// The next word is taken only after the result is loaded. The result sits in
// an output register, so a stalled result does not hold up the search of the
// following word.
module move_to_front_queue #(
  parameter int  CAPACITY = 16,
  parameter int  KEY_BITS = 16,
  localparam int IDX_W    = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [mtfq_pkg::CMD_W-1:0]      command,
  input  logic [KEY_BITS-1:0]             key,
  input  logic [mtfq_pkg::PRI_W-1:0]      priority_req,
  input  logic [IDX_W-1:0]                position,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [mtfq_pkg::STATUS_W-1:0]   status,
  output logic [KEY_BITS-1:0]             read_key,
  output logic [mtfq_pkg::PRI_W-1:0]      read_priority,
  output logic [CNT_W-1:0]                count
);
  import mtfq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [2:0]            state;
  logic [CNT_W-1:0]      occupancy;
  logic [CMD_W-1:0]      op;
  logic [KEY_BITS-1:0]   srch_key;
  logic [IDX_W-1:0]      srch_pos;
  logic [STATUS_W-1:0]   res_status;
  logic [KEY_BITS-1:0]   res_key;
  logic [PRI_W-1:0]      res_pri;
  logic                  accept;
  logic                  out_free;
  cell_ctrl_t            ctrl;

  probe_t                probe     [CAPACITY+1];
  logic [KEY_BITS-1:0]   probe_key [CAPACITY+1];
  logic [PRI_W-1:0]      probe_pri [CAPACITY+1];
  logic [KEY_BITS-1:0]   slot_key  [CAPACITY];
  logic [PRI_W-1:0]      slot_pri  [CAPACITY];

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign ctrl.wr_en    = accept && (command == CMD_APPEND) && (occupancy != CAP_CNT);
  assign ctrl.shift_en = (state == S_SHIFT);
  assign ctrl.is_read  = (op == CMD_READ);

  assign probe[0].valid = (state == S_START);
  assign probe[0].found = 1'b0;
  assign probe[0].head  = 1'b0;
  assign probe_key[0]   = '0;
  assign probe_pri[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic [PRI_W-1:0]    left_pri;

    if (i == 0) begin : g_head
      assign left_key = res_key;
      assign left_pri = res_pri;
    end else begin : g_body
      assign left_key = slot_key[i-1];
      assign left_pri = slot_pri[i-1];
    end

    mtfq_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .occupancy     (occupancy),
      .ctrl          (ctrl),
      .srch_key      (srch_key),
      .srch_pos      (srch_pos),
      .wr_key        (key),
      .wr_pri        (priority_req),
      .left_key      (left_key),
      .left_pri      (left_pri),
      .probe_in      (probe[i]),
      .probe_key_in  (probe_key[i]),
      .probe_pri_in  (probe_pri[i]),
      .probe_out     (probe[i+1]),
      .probe_key_out (probe_key[i+1]),
      .probe_pri_out (probe_pri[i+1]),
      .slot_key      (slot_key[i]),
      .slot_pri      (slot_pri[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= command;
            srch_key <= key;
            srch_pos <= position;
            unique case (command)
              CMD_APPEND: begin
                if (occupancy == CAP_CNT) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  occupancy  <= occupancy + CNT_W'(1);
                end
                state <= S_DONE;
              end
              CMD_PROMOTE: begin
                if (occupancy == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_START;
                end
              end
              CMD_READ: begin
                state <= S_START;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_START: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (probe[CAPACITY].valid) begin
            res_key <= probe_key[CAPACITY];
            res_pri <= probe_pri[CAPACITY];
            if (op == CMD_READ) begin
              res_status <= probe[CAPACITY].found ? ST_OK : ST_BAD_POS;
              state      <= S_DONE;
            end else if (!probe[CAPACITY].found) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (probe[CAPACITY].head) begin
              res_status <= ST_AT_HEAD;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      status <= res_status;
      count  <= occupancy;
      if ((op == CMD_READ) && (res_status == ST_OK)) begin
        read_key      <= res_key;
        read_priority <= res_pri;
      end else begin
        read_key      <= '0;
        read_priority <= '0;
      end
    end
  end

endmodule

// File: rtl/core/mtfq_cell.sv
// Move-to-front queue: one table slot plus one stage of the search chain.
// Depends on mtfq_pkg.
module mtfq_cell #(
  parameter int KEY_BITS = 16,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CNT_W-1:0]             occupancy,
  input  mtfq_pkg::cell_ctrl_t         ctrl,
  input  logic [KEY_BITS-1:0]          srch_key,
  input  logic [IDX_W-1:0]             srch_pos,
  input  logic [KEY_BITS-1:0]          wr_key,
  input  logic [mtfq_pkg::PRI_W-1:0]   wr_pri,
  input  logic [KEY_BITS-1:0]          left_key,
  input  logic [mtfq_pkg::PRI_W-1:0]   left_pri,
  input  mtfq_pkg::probe_t             probe_in,
  input  logic [KEY_BITS-1:0]          probe_key_in,
  input  logic [mtfq_pkg::PRI_W-1:0]   probe_pri_in,
  output mtfq_pkg::probe_t             probe_out,
  output logic [KEY_BITS-1:0]          probe_key_out,
  output logic [mtfq_pkg::PRI_W-1:0]   probe_pri_out,
  output logic [KEY_BITS-1:0]          slot_key,
  output logic [mtfq_pkg::PRI_W-1:0]   slot_pri
);
  import mtfq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_POS = IDX_W'(IDX);

  logic occupied;
  logic hit;
  logic mark;

  assign occupied = IDX_CNT < occupancy;
  assign hit = probe_in.valid && !probe_in.found && occupied &&
               (ctrl.is_read ? (srch_pos == IDX_POS) : (slot_key == srch_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.found <= probe_in.found | hit;
      probe_out.head  <= probe_in.head | (hit && (IDX == 0));
    end
  end

  always_ff @(posedge clk) begin
    probe_key_out <= hit ? slot_key : probe_key_in;
    probe_pri_out <= hit ? slot_pri : probe_pri_in;
    // set on cells at or ahead of the first match
    if (probe_in.valid) begin
      mark <= !probe_in.found;
    end
    if (ctrl.wr_en && (occupancy == IDX_CNT)) begin
      slot_key <= wr_key;
      slot_pri <= wr_pri;
    end else if (ctrl.shift_en && mark) begin
      slot_key <= left_key;
      slot_pri <= left_pri;
    end
  end

endmodule

// File: rtl/core/mtfq_checker.sv
// Move-to-front queue: port-level checks on the result channel, bound to the top.
// Depends on mtfq_pkg and move_to_front_queue.
module mtfq_checker #(
  parameter int  CAPACITY = 16,
  parameter int  KEY_BITS = 16,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [mtfq_pkg::STATUS_W-1:0] status,
  input logic [KEY_BITS-1:0]           read_key,
  input logic [mtfq_pkg::PRI_W-1:0]    read_priority,
  input logic [CNT_W-1:0]              count
);
  import mtfq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status <= ST_BAD_POS) && (count <= CAP_CNT))
    else $error("status or count out of range");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (read_key == '0) && (read_priority == '0))
    else $error("read data nonzero on failed word");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (count == CAP_CNT))
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> (count == '0))
    else $error("empty reported with entries");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(count))
    else $error("stalled result changed");

endmodule

bind move_to_front_queue mtfq_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS)
) u_mtfq_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .status        (status),
  .read_key      (read_key),
  .read_priority (read_priority),
  .count         (count)
);
